[hdl/teed_pkg.sv]
// Shared types and constants for the text encoding and line ending detector.
// No dependencies.
package teed_pkg;

   localparam logic [7:0] BYTE_EF = 8'hEF;
   localparam logic [7:0] BYTE_BB = 8'hBB;
   localparam logic [7:0] BYTE_BF = 8'hBF;
   localparam logic [7:0] BYTE_FF = 8'hFF;
   localparam logic [7:0] BYTE_FE = 8'hFE;
   localparam logic [7:0] BYTE_C2 = 8'hC2;
   localparam logic [7:0] BYTE_A0 = 8'hA0;
   localparam logic [7:0] BYTE_90 = 8'h90;
   localparam logic [7:0] BYTE_8F = 8'h8F;
   localparam logic [7:0] BYTE_E0 = 8'hE0;
   localparam logic [7:0] BYTE_ED = 8'hED;
   localparam logic [7:0] BYTE_F0 = 8'hF0;
   localparam logic [7:0] BYTE_F4 = 8'hF4;
   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_NUL = 8'h00;

   typedef enum logic [2:0] {
      ENC_UTF8_BOM = 3'd0,
      ENC_UTF16LE  = 3'd1,
      ENC_UTF16BE  = 3'd2,
      ENC_BINARY   = 3'd3,
      ENC_UTF8     = 3'd4,
      ENC_LATIN1   = 3'd5
   } teed_enc_type;

   typedef enum logic [2:0] {
      EOL_NONE  = 3'd0,
      EOL_LF    = 3'd1,
      EOL_CRLF  = 3'd2,
      EOL_CR    = 3'd3,
      EOL_MIXED = 3'd4
   } teed_eol_type;

   // range rule on the byte after a three or four byte lead
   typedef enum logic [2:0] {
      RULE_NONE     = 3'd0,
      RULE_MIN_A0   = 3'd1,
      RULE_BELOW_A0 = 3'd2,
      RULE_MIN_90   = 3'd3,
      RULE_MAX_8F   = 3'd4
   } teed_rule_type;

   typedef struct packed {
      logic       fire;
      logic       has_byte;
      logic [7:0] data;
      logic       last;
   } teed_step_type;

endpackage

[hdl/teed_utf8_val.sv]
// Streaming UTF-8 validator state and its per-byte update.
// Depends on teed_pkg.
module teed_utf8_val import teed_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  teed_step_type step,
   output logic          invalid_final
);

   logic          invalid_ff, invalid_in;
   logic [1:0]    cont_ff, cont_in;
   teed_rule_type rule_ff, rule_in;
   logic          ok;

   always_comb begin
      invalid_in = invalid_ff;
      cont_in    = cont_ff;
      rule_in    = rule_ff;
      ok         = 1'b0;
      if (step.has_byte) begin
         if (cont_ff != 2'd0) begin
            ok = (step.data[7:6] == 2'b10);
            case (rule_ff)
               RULE_MIN_A0:   ok = ok && (step.data >= BYTE_A0);
               RULE_BELOW_A0: ok = ok && (step.data < BYTE_A0);
               RULE_MIN_90:   ok = ok && (step.data >= BYTE_90);
               RULE_MAX_8F:   ok = ok && (step.data <= BYTE_8F);
               default:       ok = ok;
            endcase
            rule_in = RULE_NONE;
            if (!ok) begin
               invalid_in = 1'b1;
               cont_in    = 2'd0;
            end else begin
               cont_in = cont_ff - 2'd1;
            end
         end else if (!step.data[7]) begin
            invalid_in = invalid_ff;
         end else if (step.data[7:5] == 3'b110) begin
            if (step.data < BYTE_C2) invalid_in = 1'b1;
            else cont_in = 2'd1;
         end else if (step.data[7:4] == 4'hE) begin
            cont_in = 2'd2;
            rule_in = (step.data == BYTE_E0) ? RULE_MIN_A0 :
                      (step.data == BYTE_ED) ? RULE_BELOW_A0 : RULE_NONE;
         end else if (step.data >= BYTE_F0 && step.data <= BYTE_F4) begin
            cont_in = 2'd3;
            rule_in = (step.data == BYTE_F0) ? RULE_MIN_90 :
                      (step.data == BYTE_F4) ? RULE_MAX_8F : RULE_NONE;
         end else begin
            invalid_in = 1'b1;
         end
      end
   end

   // a cut-off sequence at end of file counts as invalid
   assign invalid_final = invalid_in || (cont_in != 2'd0);

   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last)) begin
         invalid_ff <= 1'b0;
         cont_ff    <= 2'd0;
         rule_ff    <= RULE_NONE;
      end else if (step.fire) begin
         invalid_ff <= invalid_in;
         cont_ff    <= cont_in;
         rule_ff    <= rule_in;
      end
   end

   a_rule_needs_cont: assert property (@(posedge clock) disable iff (reset)
      (rule_ff != RULE_NONE) |-> (cont_ff != 2'd0))
      else $error("range rule pending with no continuation due");

endmodule

[hdl/teed_eol_track.sv]
// Line ending tracker: CRLF, lone CR and lone LF flags and the final class.
// Depends on teed_pkg.
module teed_eol_track import teed_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  teed_step_type step,
   output teed_eol_type  eol_final
);

   logic pending_cr_ff, pending_cr_in;
   logic crlf_ff, crlf_in;
   logic lone_cr_ff, lone_cr_in;
   logic lone_lf_ff, lone_lf_in;
   logic lone_cr_end;
   logic [1:0] kinds;

   always_comb begin
      pending_cr_in = pending_cr_ff;
      crlf_in       = crlf_ff;
      lone_cr_in    = lone_cr_ff;
      lone_lf_in    = lone_lf_ff;
      if (step.has_byte) begin
         if (pending_cr_ff && step.data == BYTE_LF) begin
            crlf_in       = 1'b1;
            pending_cr_in = 1'b0;
         end else begin
            if (pending_cr_ff) lone_cr_in = 1'b1;
            pending_cr_in = (step.data == BYTE_CR);
            if (step.data == BYTE_LF) lone_lf_in = 1'b1;
         end
      end
   end

   // CR at end of file is a lone CR
   assign lone_cr_end = lone_cr_in || pending_cr_in;
   assign kinds = {1'b0, crlf_in} + {1'b0, lone_cr_end} + {1'b0, lone_lf_in};

   always_comb begin
      if (kinds == 2'd0)     eol_final = EOL_NONE;
      else if (kinds > 2'd1) eol_final = EOL_MIXED;
      else if (crlf_in)      eol_final = EOL_CRLF;
      else if (lone_cr_end)  eol_final = EOL_CR;
      else                   eol_final = EOL_LF;
   end

   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last)) begin
         pending_cr_ff <= 1'b0;
         crlf_ff       <= 1'b0;
         lone_cr_ff    <= 1'b0;
         lone_lf_ff    <= 1'b0;
      end else if (step.fire) begin
         pending_cr_ff <= pending_cr_in;
         crlf_ff       <= crlf_in;
         lone_cr_ff    <= lone_cr_in;
         lone_lf_ff    <= lone_lf_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (step.fire && step.last) |=> !(pending_cr_ff || crlf_ff || lone_cr_ff || lone_lf_ff))
      else $error("line ending flags not cleared after end of file");

endmodule

[hdl/text_encoding_eol_detector_core.sv]
// Top level of the text encoding and line ending detector.
// Depends on teed_pkg, teed_utf8_val and teed_eol_track.
//
//  channel | ports     | direction | payload
//  input   | req_*     | in        | tdata: data_byte; tuser: has_byte; tlast: last_item
//  result  | rsp_*     | out       | tdata: encoding_kind, line_ending_kind
//
// One byte per cycle, sustained while req_tready is high. A transaction passes an input
// register, then the state update and verdict logic, and a result lands in the output
// register at the edge its last item leaves the input register.
// Synchronous reset clears the valid flags and all detector state; no clearing pass is needed.
// req_tready drops only while a last item waits on a result not yet taken.
module text_encoding_eol_detector_core import teed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] has_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] encoding_kind, [5:3] line_ending_kind, [7:6] zero
);

   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic        in_has_ff;
   logic        in_last_ff;
   logic        advance;
   teed_step_type step;

   logic [23:0] head_ff, head_in;
   logic [1:0]  head_cnt_ff, head_cnt_in;
   logic        zero_ff, zero_in;

   logic         invalid_final;
   teed_eol_type eol_final;
   teed_enc_type enc_final;

   logic         out_valid_ff;
   teed_enc_type out_enc_ff;
   teed_eol_type out_eol_ff;

   assign advance    = !(in_last_ff && out_valid_ff && !rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign step.fire     = in_valid_ff && advance;
   assign step.has_byte = in_has_ff;
   assign step.data     = in_data_ff;
   assign step.last     = in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_has_ff  <= req_tuser;
         in_last_ff <= req_tlast;
      end
   end

   always_comb begin
      head_in     = head_ff;
      head_cnt_in = head_cnt_ff;
      zero_in     = zero_ff;
      if (in_has_ff) begin
         case (head_cnt_ff)
            2'd0:    head_in[7:0]   = in_data_ff;
            2'd1:    head_in[15:8]  = in_data_ff;
            2'd2:    head_in[23:16] = in_data_ff;
            default: head_in        = head_ff;
         endcase
         if (head_cnt_ff != 2'd3) head_cnt_in = head_cnt_ff + 2'd1;
         if (in_data_ff == BYTE_NUL) zero_in = 1'b1;
      end
   end

   always_comb begin
      if (head_cnt_in == 2'd3 && head_in[7:0] == BYTE_EF && head_in[15:8] == BYTE_BB &&
          head_in[23:16] == BYTE_BF)
         enc_final = ENC_UTF8_BOM;
      else if (head_cnt_in >= 2'd2 && head_in[7:0] == BYTE_FF && head_in[15:8] == BYTE_FE)
         enc_final = ENC_UTF16LE;
      else if (head_cnt_in >= 2'd2 && head_in[7:0] == BYTE_FE && head_in[15:8] == BYTE_FF)
         enc_final = ENC_UTF16BE;
      else if (zero_in)
         enc_final = ENC_BINARY;
      else if (!invalid_final)
         enc_final = ENC_UTF8;
      else
         enc_final = ENC_LATIN1;
   end

   always_ff @(posedge clock) begin
      if (reset || (step.fire && step.last)) begin
         head_ff     <= 24'd0;
         head_cnt_ff <= 2'd0;
         zero_ff     <= 1'b0;
      end else if (step.fire) begin
         head_ff     <= head_in;
         head_cnt_ff <= head_cnt_in;
         zero_ff     <= zero_in;
      end
   end

   teed_utf8_val u_utf8_val (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .invalid_final (invalid_final)
   );

   teed_eol_track u_eol_track (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .eol_final (eol_final)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step.fire && step.last) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step.fire && step.last) begin
         out_enc_ff <= enc_final;
         out_eol_ff <= eol_final;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_eol_ff, out_enc_ff};

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked result");

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      (step.fire && step.last) |=> rsp_tvalid)
      else $error("result register not loaded after end of file");

   a_enc_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= ENC_LATIN1 && rsp_tdata[5:3] <= EOL_MIXED))
      else $error("result code out of range");

endmodule

[tb/tb_text_encoding_eol_detector_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for text_encoding_eol_detector_core: streams whole files of bytes,
// predicts each file's encoding and line ending verdict and checks every result.
// Depends on teed_pkg and the detector RTL.
module tb_text_encoding_eol_detector_core;
   import teed_pkg::*;

   localparam int ITEM_TARGET    = 1550;
   localparam int QUIET_TAIL     = 200;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 30;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      teed_enc_type enc;
      teed_eol_type eol;
   } verdict_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tuser  = 1'b0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   text_encoding_eol_detector_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   byte_item_type file_stream[$];
   verdict_type   verdict_queue[$];
   int         items_planned = 0;
   int         files_planned = 0;
   int         error_count   = 0;
   int         enc_hits[6];
   int         eol_hits[5];

   // detector state mirror
   logic [23:0]   head_bytes_m;
   logic [1:0]    head_cnt_m;
   logic [1:0]    cont_left_m;
   teed_rule_type rule_m;
   bit            zero_m, bad_utf8_m, cr_pend_m, crlf_m, lone_cr_m, lone_lf_m;

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS)
         $display("%0t ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic clear_detector();
      head_bytes_m = '0;
      head_cnt_m   = '0;
      cont_left_m  = '0;
      rule_m       = RULE_NONE;
      zero_m       = 0;
      bad_utf8_m   = 0;
      cr_pend_m    = 0;
      crlf_m       = 0;
      lone_cr_m    = 0;
      lone_lf_m    = 0;
   endtask

   task automatic detector_take(input logic [7:0] c, input logic has, input logic last);
      logic        ok;
      int          kinds;
      verdict_type v;
      if (has) begin
         if (head_cnt_m < 2'd3) begin
            head_bytes_m[8*head_cnt_m +: 8] = c;
            head_cnt_m++;
         end
         if (c == BYTE_NUL) zero_m = 1;
         if (cont_left_m != 0) begin
            ok = (c[7:6] == 2'b10);
            case (rule_m)
               RULE_MIN_A0:   ok &= (c >= BYTE_A0);
               RULE_BELOW_A0: ok &= (c < BYTE_A0);
               RULE_MIN_90:   ok &= (c >= BYTE_90);
               RULE_MAX_8F:   ok &= (c <= BYTE_8F);
               default: ;
            endcase
            rule_m = RULE_NONE;
            if (!ok) begin
               bad_utf8_m  = 1;
               cont_left_m = 0;
            end else begin
               cont_left_m--;
            end
         end else if (c[7]) begin
            if (c[7:5] == 3'b110) begin
               if (c < BYTE_C2) bad_utf8_m = 1;
               else cont_left_m = 2'd1;
            end else if (c[7:4] == 4'b1110) begin
               cont_left_m = 2'd2;
               rule_m = (c == BYTE_E0) ? RULE_MIN_A0 :
                        (c == BYTE_ED) ? RULE_BELOW_A0 : RULE_NONE;
            end else if (c >= BYTE_F0 && c <= BYTE_F4) begin
               cont_left_m = 2'd3;
               rule_m = (c == BYTE_F0) ? RULE_MIN_90 :
                        (c == BYTE_F4) ? RULE_MAX_8F : RULE_NONE;
            end else begin
               bad_utf8_m = 1;
            end
         end
         if (cr_pend_m && c == BYTE_LF) begin
            crlf_m    = 1;
            cr_pend_m = 0;
         end else begin
            if (cr_pend_m) begin
               lone_cr_m = 1;
               cr_pend_m = 0;
            end
            if (c == BYTE_CR) cr_pend_m = 1;
            else if (c == BYTE_LF) lone_lf_m = 1;
         end
      end
      if (last) begin
         if (cont_left_m != 0) bad_utf8_m = 1;
         if (cr_pend_m) lone_cr_m = 1;
         if (head_cnt_m == 2'd3 && head_bytes_m == {BYTE_BF, BYTE_BB, BYTE_EF})
            v.enc = ENC_UTF8_BOM;
         else if (head_cnt_m >= 2'd2 && head_bytes_m[15:0] == {BYTE_FE, BYTE_FF})
            v.enc = ENC_UTF16LE;
         else if (head_cnt_m >= 2'd2 && head_bytes_m[15:0] == {BYTE_FF, BYTE_FE})
            v.enc = ENC_UTF16BE;
         else if (zero_m)
            v.enc = ENC_BINARY;
         else if (!bad_utf8_m)
            v.enc = ENC_UTF8;
         else
            v.enc = ENC_LATIN1;
         kinds = int'(crlf_m) + int'(lone_cr_m) + int'(lone_lf_m);
         if (kinds == 0) v.eol = EOL_NONE;
         else if (kinds > 1) v.eol = EOL_MIXED;
         else if (crlf_m) v.eol = EOL_CRLF;
         else if (lone_cr_m) v.eol = EOL_CR;
         else v.eol = EOL_LF;
         verdict_queue.push_back(v);
         clear_detector();
      end
   endtask

   // ---- stimulus construction ----

   function automatic logic [7:0] pick_between(input int lo, input int hi);
      case ($urandom_range(0, 3))
         0:       return 8'(lo);
         1:       return 8'(hi);
         default: return 8'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic add_item(input logic [7:0] data, input logic has, input logic last);
      byte_item_type it;
      it.data     = data;
      it.has_byte = has;
      it.last     = last;
      file_stream.push_back(it);
      if (has || last) items_planned++;
   endtask

   // split_end: close the file with a separate empty end item
   task automatic add_file(input logic [7:0] f[$], input bit split_end);
      for (int i = 0; i < f.size(); i++) begin
         if ($urandom_range(0, 24) == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         add_item(f[i], 1'b1, !split_end && i == f.size() - 1);
      end
      if (split_end || f.size() == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      files_planned++;
   endtask

   task automatic add_char(ref logic [7:0] f[$]);
      logic [7:0] lead;
      case ($urandom_range(0, 9))
         0, 1: f.push_back($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
         2, 3, 4: f.push_back(8'($urandom_range(1, 127)));
         5: begin
            f.push_back(pick_between(BYTE_C2, 8'hDF));
            f.push_back(pick_between(8'h80, 8'hBF));
         end
         6, 7: begin
            case ($urandom_range(0, 2))
               0:       lead = BYTE_E0;
               1:       lead = BYTE_ED;
               default: lead = pick_between(BYTE_E0, BYTE_EF);
            endcase
            f.push_back(lead);
            if (lead == BYTE_E0) f.push_back(pick_between(BYTE_A0, 8'hBF));
            else if (lead == BYTE_ED) f.push_back(pick_between(8'h80, 8'h9F));
            else f.push_back(pick_between(8'h80, 8'hBF));
            f.push_back(pick_between(8'h80, 8'hBF));
         end
         default: begin
            lead = pick_between(BYTE_F0, BYTE_F4);
            f.push_back(lead);
            if (lead == BYTE_F0) f.push_back(pick_between(BYTE_90, 8'hBF));
            else if (lead == BYTE_F4) f.push_back(pick_between(8'h80, BYTE_8F));
            else f.push_back(pick_between(8'h80, 8'hBF));
            f.push_back(pick_between(8'h80, 8'hBF));
            f.push_back(pick_between(8'h80, 8'hBF));
         end
      endcase
   endtask

   task automatic add_random_file();
      logic [7:0] f[$];
      int n, style;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      style = $urandom_range(0, 11);
      if (style < 2) begin
         case ($urandom_range(0, 4))
            0: f = '{BYTE_EF, BYTE_BB, BYTE_BF};
            1: f = '{BYTE_FF, BYTE_FE};
            2: f = '{BYTE_FE, BYTE_FF};
            3: f = '{BYTE_EF, BYTE_BB};
            default: f = '{BYTE_FE};
         endcase
      end
      repeat (n) add_char(f);
      case (style)
         6, 7: if (f.size() != 0) f[$urandom_range(0, f.size() - 1)] = 8'($urandom_range(0, 255));
         8: if (f.size() != 0) void'(f.pop_back());
         9: f.insert($urandom_range(0, f.size()), BYTE_NUL);
         10: begin
            f.delete();
            repeat (n + 1) f.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      add_file(f, 1'($urandom_range(0, 1)));
   endtask

   // ---- driver ----

   int            send_gap = 0;
   byte_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (file_stream.size() != 0) begin
            next_item = file_stream.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.data;
            req_tuser  <= next_item.has_byte;
            req_tlast  <= next_item.last;
            if (file_stream.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 9);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---- receiver ----

   int stall_left = 0;
   int hold_left  = 0;
   int rsp_taken  = 0;
   bit hold_done  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rsp_taken++;
         if (!hold_done && rsp_taken >= 20) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (file_stream.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---- monitor: check results, then predict from accepted input ----

   verdict_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected result 0x%02h", rsp_tdata));
            end else begin
               want = verdict_queue.pop_front();
               enc_hits[int'(want.enc)]++;
               eol_hits[int'(want.eol)]++;
               if (rsp_tdata[2:0] !== want.enc)
                  report_mismatch($sformatf("encoding_kind %0d, want %s",
                                            rsp_tdata[2:0], want.enc.name()));
               if (rsp_tdata[5:3] !== want.eol)
                  report_mismatch($sformatf("line_ending_kind %0d, want %s",
                                            rsp_tdata[5:3], want.eol.name()));
               if (rsp_tdata[7:6] !== 2'b00)
                  report_mismatch($sformatf("padding bits 0x%02h not zero", rsp_tdata));
            end
         end
         if (req_tvalid && req_tready) detector_take(req_tdata, req_tuser, req_tlast);
      end
   end

   // ---- watchdog ----

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ---- sequence ----

   initial begin
      logic [7:0] f[$];
      clear_detector();

      f.delete();                                  add_file(f, 1'b1); // empty file
      f = '{BYTE_EF, BYTE_BB, BYTE_BF};            add_file(f, 1'b0);
      f = '{BYTE_FF, BYTE_FE};                     add_file(f, 1'b1);
      f = '{BYTE_FE, BYTE_FF, BYTE_CR};            add_file(f, 1'b0); // CR at end
      f = '{BYTE_NUL, BYTE_LF};                    add_file(f, 1'b0);
      add_item(8'h5A, 1'b0, 1'b0);                 // empty item, ignored
      f = '{BYTE_CR, BYTE_LF, BYTE_CR};            add_file(f, 1'b0);
      f = '{8'hC0, 8'h80};                         add_file(f, 1'b0); // bad lead, stray cont.
      f = '{BYTE_F0, BYTE_90, 8'h80};              add_file(f, 1'b1); // cut off
      f = '{BYTE_F4, BYTE_90};                     add_file(f, 1'b0); // broken range
      f = '{8'hF5};                                add_file(f, 1'b0);

      while (items_planned < ITEM_TARGET) add_random_file();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (file_stream.size() != 0 || req_tvalid || verdict_queue.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d items in %0d files; bom/le/be/bin/utf8/latin1 %0d/%0d/%0d/%0d/%0d/%0d",
               items_planned, files_planned, enc_hits[0], enc_hits[1], enc_hits[2],
               enc_hits[3], enc_hits[4], enc_hits[5]);
      $display("Line endings none/lf/crlf/cr/mixed %0d/%0d/%0d/%0d/%0d, %0d mismatches",
               eol_hits[0], eol_hits[1], eol_hits[2], eol_hits[3], eol_hits[4], error_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
hdl/teed_pkg.sv
hdl/teed_utf8_val.sv
hdl/teed_eol_track.sv
hdl/text_encoding_eol_detector_core.sv
tb/tb_text_encoding_eol_detector_core.sv
